// ===== hw/rtl/mfse_pkg.sv =====
// Shared types, character codes and lookup functions of the format stream emitter.
// No dependencies.
package mfse_pkg;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_S       = 8'h73;
    localparam logic [7:0] CH_D       = 8'h64;
    localparam logic [7:0] CH_X       = 8'h78;
    localparam logic [7:0] CH_MINUS   = 8'h2d;
    localparam logic [7:0] CH_ZERO    = 8'h30;

    localparam logic [1:0] REQ_FMT   = 2'd0;
    localparam logic [1:0] REQ_WORD  = 2'd1;
    localparam logic [1:0] REQ_SBYTE = 2'd2;
    localparam logic [1:0] REQ_SEND  = 2'd3;

    localparam int          DEC_DIGITS = 10;
    localparam logic [3:0]  DEC_TOP    = 4'd9;
    localparam logic [3:0]  HEX_TOP    = 4'd7;
    localparam logic [3:0]  NULL_LAST  = 4'd5;
    localparam logic [4:0]  DAB_LAST   = 5'd31;
    localparam logic [30:0] COUNT_MAX  = 31'h7fff_ffff;

    typedef enum logic [2:0] {
        K_BYTE,
        K_SIGN,
        K_DEC,
        K_HEX,
        K_NULL,
        K_FLAG,
        K_DONE
    } emit_kind_t;

    typedef struct packed {
        logic       load;
        logic       load_mag;
        logic       dab_step;
        logic       emit;
        emit_kind_t kind;
        logic       last;
        logic [3:0] idx;
    } dp_cmd_t;

    typedef struct packed {
        logic neg;
        logic dig_nz;
        logic nib_nz;
        logic can_emit;
    } dp_stat_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] ch;
        case (nib)
            4'h0:    ch = 8'h30;
            4'h1:    ch = 8'h31;
            4'h2:    ch = 8'h32;
            4'h3:    ch = 8'h33;
            4'h4:    ch = 8'h34;
            4'h5:    ch = 8'h35;
            4'h6:    ch = 8'h36;
            4'h7:    ch = 8'h37;
            4'h8:    ch = 8'h38;
            4'h9:    ch = 8'h39;
            4'ha:    ch = 8'h61;
            4'hb:    ch = 8'h62;
            4'hc:    ch = 8'h63;
            4'hd:    ch = 8'h64;
            4'he:    ch = 8'h65;
            default: ch = 8'h66;
        endcase
        return ch;
    endfunction

    // "(null)"
    function automatic logic [7:0] null_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = 8'h28;
            3'd1:    ch = 8'h6e;
            3'd2:    ch = 8'h75;
            3'd3:    ch = 8'h6c;
            3'd4:    ch = 8'h6c;
            default: ch = 8'h29;
        endcase
        return ch;
    endfunction

endpackage

// ===== hw/rtl/mfse_dp.sv =====
// Datapath: item latch, shift-add-3 decimal converter with digit store,
// character select, saturating count and output beat register. Uses mfse_pkg.
module mfse_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  mfse_pkg::dp_cmd_t   cmd,
    output mfse_pkg::dp_stat_t  stat,
    input  logic [7:0]          data_byte,
    input  logic [31:0]         arg_word,
    input  logic                out_stall,
    output logic                out_valid,
    output logic [7:0]          out_char,
    output logic                char_valid,
    output logic [30:0]         running_count,
    output logic                done_res,
    output logic                status,
    output logic                last
);

    logic [7:0]  byte_reg;
    logic [31:0] word_reg;
    logic        neg_reg;
    logic [3:0]  digit_store_reg [mfse_pkg::DEC_DIGITS];
    logic [3:0]  adj [mfse_pkg::DEC_DIGITS];

    logic        out_valid_reg;
    logic [7:0]  out_char_reg;
    logic        char_valid_reg;
    logic [30:0] count_out_reg;
    logic        done_reg;
    logic        status_reg;
    logic        last_reg;
    logic [30:0] cnt_reg;
    logic [30:0] cnt_inc;
    logic [30:0] cnt_next;

    logic        can_emit;
    logic        fire;
    logic        is_char;
    logic [3:0]  dig;
    logic [3:0]  nib;
    logic [7:0]  ch_sel;

    assign can_emit = !out_valid_reg || !out_stall;
    assign fire     = cmd.emit && can_emit;
    assign is_char  = !(cmd.kind == mfse_pkg::K_FLAG || cmd.kind == mfse_pkg::K_DONE);
    assign dig      = (cmd.idx <= mfse_pkg::DEC_TOP) ? digit_store_reg[cmd.idx] : 4'd0;
    assign nib      = word_reg[{cmd.idx[2:0], 2'b00} +: 4];
    assign cnt_inc  = (cnt_reg == mfse_pkg::COUNT_MAX) ? cnt_reg : cnt_reg + 31'd1;

    assign stat.neg      = neg_reg;
    assign stat.dig_nz   = (dig != 4'd0);
    assign stat.nib_nz   = (nib != 4'd0);
    assign stat.can_emit = can_emit;

    always_comb
    begin
        for (int k = 0; k < mfse_pkg::DEC_DIGITS; k++)
        begin
            adj[k] = (digit_store_reg[k] >= 4'd5) ? digit_store_reg[k] + 4'd3
                                                  : digit_store_reg[k];
        end
    end

    always_comb
    begin
        case (cmd.kind)
            mfse_pkg::K_BYTE: ch_sel = byte_reg;
            mfse_pkg::K_SIGN: ch_sel = mfse_pkg::CH_MINUS;
            mfse_pkg::K_DEC:  ch_sel = mfse_pkg::CH_ZERO | {4'd0, dig};
            mfse_pkg::K_HEX:  ch_sel = mfse_pkg::hex_char(nib);
            mfse_pkg::K_NULL: ch_sel = mfse_pkg::null_char(cmd.idx[2:0]);
            default:          ch_sel = 8'd0;
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (fire)
        begin
            if (cmd.kind == mfse_pkg::K_DONE)
                cnt_next = '0;
            else if (is_char)
                cnt_next = cnt_inc;
        end
    end

    // item latch and converter
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            byte_reg <= data_byte;
            neg_reg  <= arg_word[31];
            if (cmd.load_mag)
            begin
                word_reg <= arg_word[31] ? (~arg_word + 32'd1) : arg_word;
                for (int k = 0; k < mfse_pkg::DEC_DIGITS; k++)
                    digit_store_reg[k] <= 4'd0;
            end
            else
            begin
                word_reg <= arg_word;
            end
        end
        else if (cmd.dab_step)
        begin
            word_reg           <= {word_reg[30:0], 1'b0};
            digit_store_reg[0] <= {adj[0][2:0], word_reg[31]};
            for (int k = 1; k < mfse_pkg::DEC_DIGITS; k++)
                digit_store_reg[k] <= {adj[k][2:0], adj[k-1][3]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_char_reg   <= ch_sel;
            char_valid_reg <= is_char;
            count_out_reg  <= is_char ? cnt_inc : cnt_reg;
            done_reg       <= (cmd.kind == mfse_pkg::K_DONE);
            status_reg     <= (cmd.kind == mfse_pkg::K_FLAG);
            last_reg       <= cmd.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (fire)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_char      = out_char_reg;
    assign char_valid    = char_valid_reg;
    assign running_count = count_out_reg;
    assign done_res      = done_reg;
    assign status        = status_reg;
    assign last          = last_reg;

endmodule

// ===== hw/rtl/mfse_ctrl.sv =====
// Controller: format mode tracking and the sequencer that drives the datapath
// one beat at a time. Uses mfse_pkg.
module mfse_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          req_type,
    input  logic [7:0]          data_byte,
    input  logic                arg_null,
    input  logic                format_end,
    input  mfse_pkg::dp_stat_t  stat,
    output mfse_pkg::dp_cmd_t   cmd
);

    typedef enum logic [2:0] {
        M_LIT,
        M_PCT,
        M_NUM_D,
        M_NUM_X,
        M_STR
    } mode_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHAR,
        S_FLAG,
        S_DONE,
        S_DAB,
        S_SIGN,
        S_DEC,
        S_HEX,
        S_NULL
    } state_t;

    state_t     state_reg, state_next;
    mode_t      mode_reg, mode_next;
    logic       eaa_reg, eaa_next;
    logic       pend_reg, pend_next;
    logic       started_reg, started_next;
    logic [3:0] idx_reg, idx_next;
    logic [4:0] dab_reg, dab_next;
    logic       accept;
    logic       show;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        eaa_next     = eaa_reg;
        pend_next    = pend_reg;
        started_next = started_reg;
        idx_next     = idx_reg;
        dab_next     = dab_reg;
        show         = 1'b0;

        cmd          = '0;
        cmd.kind     = mfse_pkg::K_BYTE;
        cmd.idx      = idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load = 1'b1;
                    case (mode_reg)
                        M_NUM_D, M_NUM_X:
                        begin
                            if (req_type != mfse_pkg::REQ_WORD)
                            begin
                                state_next = S_FLAG;
                            end
                            else
                            begin
                                mode_next    = M_LIT;
                                pend_next    = eaa_reg;
                                started_next = 1'b0;
                                if (mode_reg == M_NUM_D)
                                begin
                                    cmd.load_mag = 1'b1;
                                    dab_next     = '0;
                                    state_next   = S_DAB;
                                end
                                else
                                begin
                                    idx_next   = mfse_pkg::HEX_TOP;
                                    state_next = S_HEX;
                                end
                            end
                        end
                        M_STR:
                        begin
                            if (req_type == mfse_pkg::REQ_SBYTE)
                            begin
                                pend_next  = 1'b0;
                                state_next = S_CHAR;
                            end
                            else if (req_type == mfse_pkg::REQ_SEND)
                            begin
                                mode_next = M_LIT;
                                pend_next = eaa_reg;
                                if (arg_null)
                                begin
                                    idx_next   = '0;
                                    state_next = S_NULL;
                                end
                                else if (eaa_reg)
                                begin
                                    state_next = S_DONE;
                                end
                            end
                            else
                            begin
                                state_next = S_FLAG;
                            end
                        end
                        default:
                        begin
                            if (req_type != mfse_pkg::REQ_FMT)
                            begin
                                state_next = S_FLAG;
                            end
                            else if (mode_reg != M_PCT && data_byte == mfse_pkg::CH_PERCENT
                                     && !format_end)
                            begin
                                mode_next = M_PCT;
                            end
                            else if (mode_reg == M_PCT && data_byte == mfse_pkg::CH_S)
                            begin
                                mode_next = M_STR;
                                eaa_next  = format_end;
                            end
                            else if (mode_reg == M_PCT && data_byte == mfse_pkg::CH_D)
                            begin
                                mode_next = M_NUM_D;
                                eaa_next  = format_end;
                            end
                            else if (mode_reg == M_PCT && data_byte == mfse_pkg::CH_X)
                            begin
                                mode_next = M_NUM_X;
                                eaa_next  = format_end;
                            end
                            else
                            begin
                                mode_next  = M_LIT;
                                pend_next  = format_end;
                                state_next = S_CHAR;
                            end
                        end
                    endcase
                end
            end
            S_CHAR:
            begin
                cmd.emit = 1'b1;
                cmd.kind = mfse_pkg::K_BYTE;
                cmd.last = !pend_reg;
                if (stat.can_emit)
                    state_next = pend_reg ? S_DONE : S_IDLE;
            end
            S_FLAG:
            begin
                cmd.emit = 1'b1;
                cmd.kind = mfse_pkg::K_FLAG;
                cmd.last = 1'b1;
                if (stat.can_emit)
                    state_next = S_IDLE;
            end
            S_DONE:
            begin
                cmd.emit = 1'b1;
                cmd.kind = mfse_pkg::K_DONE;
                cmd.last = 1'b1;
                if (stat.can_emit)
                begin
                    pend_next  = 1'b0;
                    eaa_next   = 1'b0;
                    mode_next  = M_LIT;
                    state_next = S_IDLE;
                end
            end
            S_DAB:
            begin
                cmd.dab_step = 1'b1;
                dab_next     = dab_reg + 5'd1;
                if (dab_reg == mfse_pkg::DAB_LAST)
                begin
                    idx_next   = mfse_pkg::DEC_TOP;
                    state_next = stat.neg ? S_SIGN : S_DEC;
                end
            end
            S_SIGN:
            begin
                cmd.emit = 1'b1;
                cmd.kind = mfse_pkg::K_SIGN;
                if (stat.can_emit)
                    state_next = S_DEC;
            end
            S_DEC, S_HEX:
            begin
                cmd.kind = (state_reg == S_DEC) ? mfse_pkg::K_DEC : mfse_pkg::K_HEX;
                show     = ((state_reg == S_DEC) ? stat.dig_nz : stat.nib_nz)
                           || started_reg || (idx_reg == 4'd0);
                cmd.emit = show;
                cmd.last = (idx_reg == 4'd0) && !pend_reg;
                if (!show)
                begin
                    idx_next = idx_reg - 4'd1;
                end
                else if (stat.can_emit)
                begin
                    started_next = 1'b1;
                    if (idx_reg == 4'd0)
                        state_next = pend_reg ? S_DONE : S_IDLE;
                    else
                        idx_next = idx_reg - 4'd1;
                end
            end
            S_NULL:
            begin
                cmd.emit = 1'b1;
                cmd.kind = mfse_pkg::K_NULL;
                cmd.last = (idx_reg == mfse_pkg::NULL_LAST) && !pend_reg;
                if (stat.can_emit)
                begin
                    if (idx_reg == mfse_pkg::NULL_LAST)
                        state_next = pend_reg ? S_DONE : S_IDLE;
                    else
                        idx_next = idx_reg + 4'd1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            mode_reg    <= M_LIT;
            eaa_reg     <= 1'b0;
            pend_reg    <= 1'b0;
            started_reg <= 1'b0;
            idx_reg     <= '0;
            dab_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            eaa_reg     <= eaa_next;
            pend_reg    <= pend_next;
            started_reg <= started_next;
            idx_reg     <= idx_next;
            dab_reg     <= dab_next;
        end
    end

endmodule

// ===== hw/rtl/mini_format_stream_emitter_unit.sv =====
// Timing: a plain byte or a flagged beat passes the sequencer state register and then the
// output beat register after acceptance; %d loads the word, runs the converter, then steps the sign and every digit
// position, leading zeros included; %x steps every nibble; each beat waits while the output is stalled.
// Throughput: one item in flight; input taken again once its last beat is registered.
// Reset: rst_n asynchronous, active low; clears mode, sequencer, count and output valid.
// Top level of the format stream emitter. Depends on mfse_pkg, mfse_ctrl and mfse_dp.
module mini_format_stream_emitter_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [7:0]  data_byte,
    input  logic [31:0] arg_word,
    input  logic        arg_null,
    input  logic        format_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_char,
    output logic        char_valid,
    output logic [30:0] running_count,
    output logic        done_res,
    output logic        status,
    output logic        last
);

    mfse_pkg::dp_cmd_t  cmd;
    mfse_pkg::dp_stat_t stat;

    mfse_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .data_byte  (data_byte),
        .arg_null   (arg_null),
        .format_end (format_end),
        .stat       (stat),
        .cmd        (cmd)
    );

    mfse_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .data_byte     (data_byte),
        .arg_word      (arg_word),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .out_char      (out_char),
        .char_valid    (char_valid),
        .running_count (running_count),
        .done_res      (done_res),
        .status        (status),
        .last          (last)
    );

endmodule

// ===== hw/rtl/mfse_checker.sv =====
// Port-level checker for the format stream emitter, bound to the top level.
// Depends on mini_format_stream_emitter_unit.
module mfse_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [7:0]  out_char,
    input logic        char_valid,
    input logic [30:0] running_count,
    input logic        done_res,
    input logic        status,
    input logic        last
);

    a_beat_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(running_count))
        else $error("stalled beat changed");

    a_blank_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !char_valid |-> out_char == 8'd0)
        else $error("non-character beat carries a character");

    a_done_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> last && !char_valid && !status)
        else $error("malformed done beat");

    a_flag_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> last && !char_valid && !done_res)
        else $error("malformed flagged beat");

endmodule

bind mini_format_stream_emitter_unit mfse_checker u_mfse_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char      (out_char),
    .char_valid    (char_valid),
    .running_count (running_count),
    .done_res      (done_res),
    .status        (status),
    .last          (last)
);

// ===== tb/mini_format_stream_emitter_unit_tb.sv =====
// Self-checking testbench for mini_format_stream_emitter_unit: format, argument and noise
// beats go in and every emitted character, flag and done beat is checked against a predictor.
// Depends on mfse_pkg and the RTL of the unit.
module mini_format_stream_emitter_unit_tb;

    localparam logic [7:0] CH_LOWER_A   = 8'h61;
    localparam logic [7:0] CH_Q         = 8'h71;
    localparam logic [7:0] CH_UPPER_A   = 8'h41;
    localparam logic       ST_OK        = 1'b0;
    localparam logic       ST_FLAGGED   = 1'b1;
    localparam string      NULL_TEXT    = "(null)";
    localparam int         RAND_ITEMS   = 100;
    localparam int         HOLDOFF_CYC  = 150;
    localparam int         HOLDOFF_AT   = 45;
    localparam int         STUCK_LIMIT  = 2000;
    localparam int         TAIL_CYC     = 60;

    typedef enum logic [2:0] {
        M_LIT,
        M_PCT,
        M_DEC,
        M_HEX,
        M_STR
    } fmt_mode_t;

    typedef struct {
        logic [1:0]  rt;
        logic [7:0]  b;
        logic [31:0] w;
        logic        nl;
        logic        fe;
        bit          drain;
    } fmt_item_t;

    typedef struct {
        logic [7:0]  ch;
        logic        cv;
        logic [30:0] cnt;
        logic        done;
        logic        st;
        logic        last;
    } fmt_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  req_type = mfse_pkg::REQ_FMT;
    logic [7:0]  data_byte = 8'h00;
    logic [31:0] arg_word = 32'h0;
    logic        arg_null = 1'b0;
    logic        format_end = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  out_char;
    logic        char_valid;
    logic [30:0] running_count;
    logic        done_res;
    logic        status;
    logic        last;

    fmt_item_t   pend_q[$];
    fmt_beat_t   exp_q[$];
    bit          drain_next = 1'b0;
    bit          in_taken = 1'b0;
    int          n_acc = 0;
    int          n_errs = 0;
    int          stuck_cyc = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    logic        quiet;

    fmt_mode_t   mode = M_LIT;
    logic [30:0] char_total = '0;
    logic        end_after_arg = 1'b0;

    assign quiet = (n_acc >= 90) && (n_acc < 120);

    mini_format_stream_emitter_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .data_byte     (data_byte),
        .arg_word      (arg_word),
        .arg_null      (arg_null),
        .format_end    (format_end),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_char      (out_char),
        .char_valid    (char_valid),
        .running_count (running_count),
        .done_res      (done_res),
        .status        (status),
        .last          (last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ---------------- predictor ----------------

    task automatic put_beat(input logic [7:0] ch, input logic cv, input logic dn,
                            input logic st);
        fmt_beat_t e;
        e.ch   = ch;
        e.cv   = cv;
        e.cnt  = char_total;
        e.done = dn;
        e.st   = st;
        e.last = 1'b0;
        exp_q.push_back(e);
    endtask

    task automatic put_char(input logic [7:0] ch);
        if (char_total != mfse_pkg::COUNT_MAX)
            char_total = char_total + 31'd1;
        put_beat(ch, 1'b1, 1'b0, ST_OK);
    endtask

    task automatic put_done();
        put_beat(8'h00, 1'b0, 1'b1, ST_OK);
        mode          = M_LIT;
        end_after_arg = 1'b0;
        char_total    = '0;
    endtask

    task automatic put_decimal(input logic [31:0] w);
        logic [31:0] mag;
        logic [3:0]  digs [10];
        int          n;
        int          i;
        mag = w;
        n   = 0;
        if (w[31])
        begin
            put_char(mfse_pkg::CH_MINUS);
            mag = -w;
        end
        do
        begin
            digs[n] = 4'(mag % 32'd10);
            n++;
            mag = mag / 32'd10;
        end while (mag != 0);
        for (i = n - 1; i >= 0; i--)
            put_char(mfse_pkg::CH_ZERO + {4'd0, digs[i]});
    endtask

    task automatic put_hex(input logic [31:0] w);
        logic [3:0] nib;
        bit         started;
        int         i;
        started = 1'b0;
        for (i = 7; i >= 0; i--)
        begin
            nib = w[i*4 +: 4];
            if (nib != 4'd0 || started || i == 0)
            begin
                started = 1'b1;
                if (nib < 4'd10)
                    put_char(mfse_pkg::CH_ZERO + {4'd0, nib});
                else
                    put_char(CH_LOWER_A + {4'd0, nib} - 8'd10);
            end
        end
    endtask

    task automatic predict_beats(input logic [1:0] rt, input logic [7:0] b,
                                 input logic [31:0] w, input logic nl, input logic fe);
        fmt_beat_t e;
        int        n0;
        int        i;
        n0 = exp_q.size();
        case (mode)
            M_LIT, M_PCT:
            begin
                if (rt != mfse_pkg::REQ_FMT)
                    put_beat(8'h00, 1'b0, 1'b0, ST_FLAGGED);
                else if (mode == M_LIT && b == mfse_pkg::CH_PERCENT && !fe)
                    mode = M_PCT;
                else if (mode == M_PCT && (b == mfse_pkg::CH_S || b == mfse_pkg::CH_D
                                           || b == mfse_pkg::CH_X))
                begin
                    mode          = (b == mfse_pkg::CH_S) ? M_STR
                                  : ((b == mfse_pkg::CH_D) ? M_DEC : M_HEX);
                    end_after_arg = fe;
                end
                else
                begin
                    mode = M_LIT;
                    put_char(b);
                    if (fe)
                        put_done();
                end
            end
            M_DEC, M_HEX:
            begin
                if (rt != mfse_pkg::REQ_WORD)
                    put_beat(8'h00, 1'b0, 1'b0, ST_FLAGGED);
                else
                begin
                    if (mode == M_DEC)
                        put_decimal(w);
                    else
                        put_hex(w);
                    mode = M_LIT;
                    if (end_after_arg)
                        put_done();
                end
            end
            default:
            begin
                if (rt == mfse_pkg::REQ_SBYTE)
                    put_char(b);
                else if (rt == mfse_pkg::REQ_SEND)
                begin
                    if (nl)
                        for (i = 0; i < 6; i++)
                            put_char(NULL_TEXT[i]);
                    mode = M_LIT;
                    if (end_after_arg)
                        put_done();
                end
                else
                    put_beat(8'h00, 1'b0, 1'b0, ST_FLAGGED);
            end
        endcase
        if (exp_q.size() > n0)
        begin
            e      = exp_q.pop_back();
            e.last = 1'b1;
            exp_q.push_back(e);
        end
    endtask

    task automatic cmp_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
        if (got !== want)
        begin
            n_errs++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, want, got);
        end
    endtask

    // ---------------- stimulus ----------------

    task automatic add_item(input logic [1:0] rt, input logic [7:0] b, input logic [31:0] w,
                            input logic nl, input logic fe);
        fmt_item_t it;
        it.rt    = rt;
        it.b     = b;
        it.w     = w;
        it.nl    = nl;
        it.fe    = fe;
        it.drain = drain_next;
        drain_next = 1'b0;
        pend_q.push_back(it);
    endtask

    function automatic logic [31:0] pick_word();
        logic [31:0] w;
        case ($urandom_range(3))
            0: w = $urandom;
            1: w = $urandom_range(99);
            2: w = $urandom >> $urandom_range(31);
            default:
                case ($urandom_range(4))
                    0:       w = 32'h0000_0000;
                    1:       w = 32'h8000_0000;
                    2:       w = 32'h7fff_ffff;
                    3:       w = 32'hffff_ffff;
                    default: w = 32'h8000_0001;
                endcase
        endcase
        return w;
    endfunction

    initial
    begin
        int          sel;
        int          k;
        int          n_noise;
        int          n_seg;
        int          n_dir;
        logic        fe;
        logic [7:0]  b;

        // directed
        add_item(mfse_pkg::REQ_FMT,   CH_UPPER_A, $urandom, 1'($urandom), 1'b0);
        add_item(mfse_pkg::REQ_FMT,   8'h00,      $urandom, 1'($urandom), 1'b0);
        add_item(mfse_pkg::REQ_FMT,   8'hff,      $urandom, 1'($urandom), 1'b0);
        add_item(mfse_pkg::REQ_WORD,  8'($urandom), $urandom, 1'($urandom), 1'($urandom));
        add_item(mfse_pkg::REQ_FMT,   mfse_pkg::CH_PERCENT, $urandom, 1'($urandom), 1'b0);
        add_item(mfse_pkg::REQ_FMT,   mfse_pkg::CH_D, $urandom, 1'($urandom), 1'b0);
        add_item(mfse_pkg::REQ_FMT,   CH_Q,       $urandom, 1'($urandom), 1'b0);
        add_item(mfse_pkg::REQ_SEND,  8'($urandom), $urandom, 1'b1, 1'($urandom));
        add_item(mfse_pkg::REQ_WORD,  8'($urandom), 32'h8000_0000, 1'($urandom),
                 1'($urandom));
        add_item(mfse_pkg::REQ_FMT,   mfse_pkg::CH_PERCENT, $urandom, 1'($urandom), 1'b0);
        add_item(mfse_pkg::REQ_FMT,   mfse_pkg::CH_S, $urandom, 1'($urandom), 1'b0);
        add_item(mfse_pkg::REQ_SBYTE, 8'h00,      $urandom, 1'($urandom), 1'($urandom));
        add_item(mfse_pkg::REQ_WORD,  8'($urandom), $urandom, 1'($urandom), 1'($urandom));
        add_item(mfse_pkg::REQ_SBYTE, 8'hff,      $urandom, 1'($urandom), 1'($urandom));
        add_item(mfse_pkg::REQ_SEND,  8'($urandom), $urandom, 1'b1, 1'($urandom));
        add_item(mfse_pkg::REQ_FMT,   mfse_pkg::CH_PERCENT, $urandom, 1'($urandom), 1'b0);
        add_item(mfse_pkg::REQ_FMT,   mfse_pkg::CH_PERCENT, $urandom, 1'($urandom), 1'b0);
        add_item(mfse_pkg::REQ_FMT,   mfse_pkg::CH_PERCENT, $urandom, 1'($urandom), 1'b0);
        add_item(mfse_pkg::REQ_FMT,   mfse_pkg::CH_X, $urandom, 1'($urandom), 1'b1);
        add_item(mfse_pkg::REQ_WORD,  8'($urandom), 32'h0, 1'($urandom), 1'($urandom));
        add_item(mfse_pkg::REQ_FMT,   mfse_pkg::CH_PERCENT, $urandom, 1'($urandom), 1'b1);
        add_item(mfse_pkg::REQ_FMT,   mfse_pkg::CH_PERCENT, $urandom, 1'($urandom), 1'b0);
        add_item(mfse_pkg::REQ_FMT,   mfse_pkg::CH_X, $urandom, 1'($urandom), 1'b0);
        add_item(mfse_pkg::REQ_WORD,  8'($urandom), 32'hffff_ffff, 1'($urandom),
                 1'($urandom));
        add_item(mfse_pkg::REQ_FMT,   CH_UPPER_A, $urandom, 1'($urandom), 1'b1);
        n_dir = pend_q.size();

        // random: mostly well-formed conversions, some stray beats
        n_noise = 0;
        n_seg   = 0;
        while (pend_q.size() < n_dir + RAND_ITEMS + n_noise)
        begin
            sel = $urandom_range(99);
            fe  = ($urandom_range(7) == 0);
            if (n_seg == 25)
                drain_next = 1'b1;
            n_seg++;
            if (sel < 10)
            begin
                add_item(2'($urandom_range(3)), 8'($urandom), $urandom, 1'($urandom),
                         1'($urandom));
                n_noise++;
            end
            else if (sel < 30)
            begin
                b = 8'($urandom);
                if (b == mfse_pkg::CH_PERCENT)
                    b = CH_UPPER_A;
                add_item(mfse_pkg::REQ_FMT, b, $urandom, 1'($urandom), fe);
            end
            else if (sel < 65)
            begin
                add_item(mfse_pkg::REQ_FMT, mfse_pkg::CH_PERCENT, $urandom, 1'($urandom),
                         1'b0);
                add_item(mfse_pkg::REQ_FMT, (sel < 50) ? mfse_pkg::CH_D : mfse_pkg::CH_X,
                         $urandom, 1'($urandom), fe);
                add_item(mfse_pkg::REQ_WORD, 8'($urandom), pick_word(), 1'($urandom),
                         1'($urandom));
            end
            else if (sel < 85)
            begin
                add_item(mfse_pkg::REQ_FMT, mfse_pkg::CH_PERCENT, $urandom, 1'($urandom),
                         1'b0);
                add_item(mfse_pkg::REQ_FMT, mfse_pkg::CH_S, $urandom, 1'($urandom), fe);
                for (k = $urandom_range(4); k > 0; k--)
                    add_item(mfse_pkg::REQ_SBYTE, 8'($urandom), $urandom, 1'($urandom),
                             1'($urandom));
                add_item(mfse_pkg::REQ_SEND, 8'($urandom), $urandom,
                         ($urandom_range(3) == 0), 1'($urandom));
            end
            else if (sel < 92)
            begin
                b = 8'($urandom);
                if (b == mfse_pkg::CH_S || b == mfse_pkg::CH_D || b == mfse_pkg::CH_X)
                    b = mfse_pkg::CH_PERCENT;
                add_item(mfse_pkg::REQ_FMT, mfse_pkg::CH_PERCENT, $urandom, 1'($urandom),
                         1'b0);
                add_item(mfse_pkg::REQ_FMT, b, $urandom, 1'($urandom), fe);
            end
            else
                add_item(mfse_pkg::REQ_FMT, mfse_pkg::CH_PERCENT, $urandom, 1'($urandom),
                         1'b1);
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pend_q.size() != 0 || in_valid)
            @(posedge clk);
        while (exp_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYC) @(posedge clk);
        if (n_errs == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // ---------------- driver ----------------

    always @(negedge clk)
    begin
        fmt_item_t it;
        bit        give;
        give = 1'b0;
        if (rst_n)
        begin
            if (in_valid && !in_taken)
                give = 1'b1;
            else if (pend_q.size() != 0 && !(pend_q[0].drain && exp_q.size() != 0)
                     && (quiet || $urandom_range(99) >= 15))
            begin
                it = pend_q.pop_front();
                req_type   <= it.rt;
                data_byte  <= it.b;
                arg_word   <= it.w;
                arg_null   <= it.nl;
                format_end <= it.fe;
                give = 1'b1;
            end
        end
        in_valid <= give;
    end

    // receiver back-pressure, with one long hold-off
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (!hold_done && n_acc == HOLDOFF_AT)
        begin
            hold_left <= HOLDOFF_CYC;
            hold_done <= 1'b1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !quiet && ($urandom_range(99) < 15);
    end

    // ---------------- monitor ----------------

    always @(posedge clk)
    begin
        fmt_beat_t e;
        bit        fire_in;
        bit        fire_out;
        fire_in  = rst_n && in_valid && !in_stall;
        fire_out = rst_n && out_valid && !out_stall;
        in_taken <= fire_in;
        if (fire_in)
        begin
            predict_beats(req_type, data_byte, arg_word, arg_null, format_end);
            n_acc <= n_acc + 1;
        end
        if (fire_out)
        begin
            if (exp_q.size() == 0)
            begin
                n_errs++;
                $display("%0t: beat with nothing expected, got char %0h valid %0b count %0h",
                         $time, out_char, char_valid, running_count);
            end
            else
            begin
                e = exp_q.pop_front();
                cmp_field("out_char",      32'(e.ch),   32'(out_char));
                cmp_field("char_valid",    32'(e.cv),   32'(char_valid));
                cmp_field("running_count", 32'(e.cnt),  32'(running_count));
                cmp_field("done_res",      32'(e.done), 32'(done_res));
                cmp_field("status",        32'(e.st),   32'(status));
                cmp_field("last",          32'(e.last), 32'(last));
            end
        end
        stuck_cyc <= (fire_in || fire_out) ? 0 : stuck_cyc + 1;
    end

    initial
    begin
        while (stuck_cyc < STUCK_LIMIT)
            @(posedge clk);
        $display("Test completed with failures");
        $finish;
    end

endmodule
